/* src/pks_pkg.sv */
// Shared types, widths and codes for the preemptive key scheduler.
// No dependencies; every other file imports this package.
package pks_pkg;

    // Table size and tick counter width
    localparam int SLOT_COUNT = 16;
    localparam int TIME_WIDTH = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    // Field widths fixed by the item formats
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 8;
    localparam int DUR_W    = 16;
    localparam int KEY_W    = 16;
    localparam int ACTION_W = 2;
    localparam int POLICY_W = 2;
    localparam int USED_W   = 5;
    localparam int CMP_W    = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;

    // Compare tree: first level reduces groups of four slots
    localparam int GROUP_SIZE = 4;
    localparam int GROUP_N    = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

    // Policy codes (any other value selects priority)
    localparam logic [POLICY_W-1:0] POL_ARRIVAL = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BURST   = 2'd1;
    localparam logic [POLICY_W-1:0] POL_PRIO    = 2'd2;

    // Register map (index taken from paddr[2])
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_SLOTS  = 1'b1;
    localparam int   PADDR_W    = 3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [3:0]          slot;
        logic [ID_W-1:0]     proc_id;
        logic [PRIO_W-1:0]   prio;
        logic [DUR_W-1:0]    arrival;
        logic [DUR_W-1:0]    burst;
    } in_item_t;

    typedef struct packed {
        logic [15:0]     tick_time;
        logic [ID_W-1:0] run_id;
        logic            idle;
        logic            first_run;
        logic            finished;
        logic            all_done;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic restart;
        logic mark;
        logic sel_a;
        logic sel_b;
        logic commit;
    } dp_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_SEL_A,
        ST_SEL_B,
        ST_COMMIT
    } ctrl_state_t;

endpackage

/* src/pks_ctrl.sv */
// Controller state machine of the preemptive key scheduler.
// Depends on pks_pkg; drives the datapath through a dp_cmd_t bundle.
module pks_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic [pks_pkg::ACTION_W-1:0]  action,
    input  logic                          result_stall,
    output logic                          item_stall,
    output logic                          result_valid,
    output pks_pkg::dp_cmd_t              cmd
);
    import pks_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    logic        accept;

    // Hold state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Sequence one transaction at a time; commit only into a free output slot
    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        item_stall        = (state_reg != ST_IDLE);
        accept            = item_valid && !item_stall;
        result_valid_next = result_valid_reg && result_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_LOAD:    cmd.load = 1'b1;
                        ACT_RESTART: cmd.restart = 1'b1;
                        ACT_TICK:    state_next = ST_MARK;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = ST_SEL_A;
            end
            ST_SEL_A:
            begin
                cmd.sel_a  = 1'b1;
                state_next = ST_SEL_B;
            end
            ST_SEL_B:
            begin
                cmd.sel_b  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.commit        = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;

endmodule

/* src/pks_dp.sv */
// Datapath of the preemptive key scheduler: slot table, ready marks,
// two-level registered compare tree, tick counter and result register. Uses pks_pkg.
module pks_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pks_pkg::dp_cmd_t              cmd,
    input  pks_pkg::in_item_t             item,
    input  logic [pks_pkg::POLICY_W-1:0]  policy,
    input  logic [pks_pkg::USED_W-1:0]    slots_in_use,
    output pks_pkg::out_item_t            result
);
    import pks_pkg::*;

    // Slot table payload
    logic [ID_W-1:0]   id_reg      [SLOT_COUNT];
    logic [PRIO_W-1:0] prio_reg    [SLOT_COUNT];
    logic [DUR_W-1:0]  arrival_reg [SLOT_COUNT];
    logic [DUR_W-1:0]  burst_reg   [SLOT_COUNT];

    // Run state
    logic [DUR_W-1:0]      rem_reg    [SLOT_COUNT];
    logic [DUR_W-1:0]      rem_next   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] ready_reg;
    logic [SLOT_COUNT-1:0] ready_next;
    logic [TIME_WIDTH-1:0] tick_reg;
    logic [TIME_WIDTH-1:0] tick_next;

    // Compare tree
    logic              grp_valid_reg [GROUP_N];
    logic [SLOT_W-1:0] grp_idx_reg   [GROUP_N];
    logic [KEY_W-1:0]  grp_key_reg   [GROUP_N];
    logic              grp_valid     [GROUP_N];
    logic [SLOT_W-1:0] grp_idx       [GROUP_N];
    logic [KEY_W-1:0]  grp_key       [GROUP_N];
    logic              best_valid_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic              best_valid;
    logic [SLOT_W-1:0] best_idx;
    logic [KEY_W-1:0]  best_key;

    out_item_t result_reg;
    out_item_t result_next;

    logic [SLOT_COUNT-1:0] in_use;
    logic [SLOT_COUNT-1:0] elig;
    logic [KEY_W-1:0]      slot_key [SLOT_COUNT];
    logic                  load_ok;
    logic [SLOT_W-1:0]     load_idx;
    logic [DUR_W-1:0]      rem_best;
    logic [DUR_W-1:0]      rem_dec;
    logic                  all_done;

    function automatic logic [KEY_W-1:0] key_of(
        input logic [POLICY_W-1:0] pol,
        input logic [DUR_W-1:0]    arr,
        input logic [DUR_W-1:0]    bur,
        input logic [PRIO_W-1:0]   pri
    );
        logic [KEY_W-1:0] k;
        case (pol)
            POL_ARRIVAL: k = KEY_W'(arr);
            POL_BURST:   k = KEY_W'(bur);
            default:     k = KEY_W'(pri);
        endcase
        return k;
    endfunction

    assign load_ok  = (32'(item.slot) < SLOT_COUNT);
    assign load_idx = SLOT_W'(item.slot);

    // Decode slots in use, eligibility and keys
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            in_use[i]   = (32'(i) < 32'(slots_in_use));
            elig[i]     = in_use[i] && ready_reg[i] && (rem_reg[i] != '0);
            slot_key[i] = key_of(policy, arrival_reg[i], burst_reg[i], prio_reg[i]);
        end
    end

    // First tree level: least key in each group, lowest index on ties
    always_comb
    begin
        for (int g = 0; g < GROUP_N; g++)
        begin
            grp_valid[g] = 1'b0;
            grp_idx[g]   = '0;
            grp_key[g]   = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if ((g * GROUP_SIZE + j) < SLOT_COUNT)
                begin
                    if (elig[g * GROUP_SIZE + j] &&
                        (!grp_valid[g] || (slot_key[g * GROUP_SIZE + j] < grp_key[g])))
                    begin
                        grp_valid[g] = 1'b1;
                        grp_idx[g]   = SLOT_W'(g * GROUP_SIZE + j);
                        grp_key[g]   = slot_key[g * GROUP_SIZE + j];
                    end
                end
            end
        end
    end

    // Second tree level over the group winners
    always_comb
    begin
        best_valid = 1'b0;
        best_idx   = '0;
        best_key   = '0;
        for (int g = 0; g < GROUP_N; g++)
        begin
            if (grp_valid_reg[g] && (!best_valid || (grp_key_reg[g] < best_key)))
            begin
                best_valid = 1'b1;
                best_idx   = grp_idx_reg[g];
                best_key   = grp_key_reg[g];
            end
        end
    end

    // Dispatch the winner and check for remaining work
    assign rem_best = rem_reg[best_idx_reg];
    assign rem_dec  = rem_best - 1'b1;

    always_comb
    begin
        all_done = 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (in_use[i])
            begin
                if (best_valid_reg && (SLOT_W'(i) == best_idx_reg))
                begin
                    if (rem_dec != '0)
                        all_done = 1'b0;
                end
                else if (rem_reg[i] != '0)
                begin
                    all_done = 1'b0;
                end
            end
        end

        result_next.tick_time = 16'(tick_reg);
        result_next.run_id    = best_valid_reg ? id_reg[best_idx_reg] : '0;
        result_next.idle      = !best_valid_reg;
        result_next.first_run = best_valid_reg && (rem_best == burst_reg[best_idx_reg]);
        result_next.finished  = best_valid_reg && (rem_dec == '0);
        result_next.all_done  = all_done;
    end

    // Next run state: load, restart, arrival marking and dispatch
    always_comb
    begin
        rem_next   = rem_reg;
        ready_next = ready_reg;
        tick_next  = tick_reg;

        if (cmd.load && load_ok)
        begin
            rem_next[load_idx]   = item.burst;
            ready_next[load_idx] = 1'b0;
        end

        if (cmd.restart)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                rem_next[i] = burst_reg[i];
            ready_next = '0;
            tick_next  = '0;
        end

        if (cmd.mark)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (in_use[i] && (CMP_W'(arrival_reg[i]) == CMP_W'(tick_reg)))
                    ready_next[i] = 1'b1;
            end
        end

        if (cmd.commit)
        begin
            if (best_valid_reg)
                rem_next[best_idx_reg] = rem_dec;
            if (tick_reg != '1)
                tick_next = tick_reg + 1'b1;
        end
    end

    // Hold run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                rem_reg[i] <= '0;
            ready_reg <= '0;
            tick_reg  <= '0;
        end
        else
        begin
            rem_reg   <= rem_next;
            ready_reg <= ready_next;
            tick_reg  <= tick_next;
        end
    end

    // Write slot payload on a load
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            id_reg[load_idx]      <= item.proc_id;
            prio_reg[load_idx]    <= item.prio;
            arrival_reg[load_idx] <= item.arrival;
            burst_reg[load_idx]   <= item.burst;
        end
    end

    // Advance the compare tree and capture the result
    always_ff @(posedge clk)
    begin
        if (cmd.sel_a)
        begin
            grp_valid_reg <= grp_valid;
            grp_idx_reg   <= grp_idx;
            grp_key_reg   <= grp_key;
        end
        if (cmd.sel_b)
        begin
            best_valid_reg <= best_valid;
            best_idx_reg   <= best_idx;
        end
        if (cmd.commit)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

/* src/preemptive_key_scheduler.sv */
// Preemptive key scheduler. A load or restart transaction is taken in the
// cycle in which it is accepted. A tick transaction then holds the input
// through the controller states MARK (mark arrivals), SEL_A and SEL_B (the
// two levels of the registered compare tree over the slots: groups of four,
// then the group winners) and COMMIT (commit the dispatch into the result
// register, which also sets result_valid). The next transaction can be
// accepted once the controller is back in idle; the commit waits in COMMIT
// only while a previous result is still stalled.
// No new transaction is accepted while a tick is in progress.
// Depends on pks_pkg, pks_ctrl and pks_dp.
module preemptive_key_scheduler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  pks_pkg::in_item_t            item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output pks_pkg::out_item_t           result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pks_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pks_pkg::*;

    logic [POLICY_W-1:0] policy_reg;
    logic [USED_W-1:0]   slots_reg;
    logic                cfg_write;
    dp_cmd_t             cmd;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_BURST;
            slots_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_POLICY: policy_reg <= pwdata[POLICY_W-1:0];
                REG_SLOTS:  slots_reg  <= pwdata[USED_W-1:0];
                default:    slots_reg  <= slots_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_POLICY: prdata = 32'(policy_reg);
            REG_SLOTS:  prdata = 32'(slots_reg);
            default:    prdata = '0;
        endcase
    end

    pks_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .action       (item.action),
        .result_stall (result_stall),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    pks_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .policy       (policy_reg),
        .slots_in_use (slots_reg),
        .result       (result)
    );

    // An accepted tick blocks further transactions until it commits
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (item.action == ACT_TICK)) |=> item_stall)
        else $error("tick accepted without entering its sequence");

    // A commit never overwrites a pending result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!result_valid || !result_stall))
        else $error("commit over a stalled result");

    // A commit always presents a result next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid)
        else $error("commit without result");

    // Table writes only happen from idle with the input open
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load || cmd.restart) |-> (item_valid && !item_stall))
        else $error("table write outside an accepted transaction");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for preemptive_key_scheduler: a queue-fed driver, a monitor and
// a dispatch predictor kept in step with the block's slot table.
// Depends on pks_pkg and the scheduler RTL.
module testbench;

    import pks_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int STEADY_TICKS  = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 33;

    // Action code that the block ignores
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    in_item_t            item         = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    out_item_t           result;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [31:0]         pwdata       = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Stimulus and expectation stores
    in_item_t  pending[$];
    out_item_t dispatch_q[$];
    bit        steady   = 1'b0;
    int        failures = 0;
    int        fed      = 0;
    int        cycles   = 0;

    // Predicted slot table and registers
    logic [ID_W-1:0]       tbl_pid    [SLOT_COUNT] = '{default: '0};
    logic [PRIO_W-1:0]     tbl_prio   [SLOT_COUNT] = '{default: '0};
    logic [DUR_W-1:0]      tbl_arrive [SLOT_COUNT] = '{default: '0};
    logic [DUR_W-1:0]      tbl_need   [SLOT_COUNT] = '{default: '0};
    logic [DUR_W-1:0]      tbl_left   [SLOT_COUNT] = '{default: '0};
    logic                  tbl_seen   [SLOT_COUNT] = '{default: 1'b0};
    logic [TIME_WIDTH-1:0] now_tick   = '0;
    logic [POLICY_W-1:0]   cfg_policy = POL_BURST;
    logic [USED_W-1:0]     cfg_used   = '0;

    preemptive_key_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Work out the dispatch that one accepted transaction causes
    function automatic void predict_dispatch(input in_item_t it);
        int          used;
        int          pick;
        logic [15:0] pick_key;
        logic [15:0] k;
        out_item_t   r;
        used = (cfg_used > SLOT_COUNT) ? SLOT_COUNT : int'(cfg_used);
        case (it.action)
            ACT_LOAD:
            begin
                tbl_pid[it.slot]    = it.proc_id;
                tbl_prio[it.slot]   = it.prio;
                tbl_arrive[it.slot] = it.arrival;
                tbl_need[it.slot]   = it.burst;
                tbl_left[it.slot]   = it.burst;
                tbl_seen[it.slot]   = 1'b0;
            end
            ACT_RESTART:
            begin
                now_tick = '0;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    tbl_left[i] = tbl_need[i];
                    tbl_seen[i] = 1'b0;
                end
            end
            ACT_TICK:
            begin
                // mark arrivals; an arrived mark is kept, so a slot arrives once
                for (int i = 0; i < used; i++)
                    if (!tbl_seen[i] && tbl_arrive[i] == now_tick)
                        tbl_seen[i] = 1'b1;
                // least key wins, ties to the lowest slot
                pick     = -1;
                pick_key = '0;
                for (int i = 0; i < used; i++)
                begin
                    if (tbl_seen[i] && tbl_left[i] != 0)
                    begin
                        case (cfg_policy)
                            POL_ARRIVAL: k = tbl_arrive[i];
                            POL_BURST:   k = tbl_need[i];
                            default:     k = 16'(tbl_prio[i]);
                        endcase
                        if (pick < 0 || k < pick_key)
                        begin
                            pick     = i;
                            pick_key = k;
                        end
                    end
                end
                r           = '0;
                r.tick_time = now_tick;
                r.idle      = (pick < 0);
                r.all_done  = 1'b1;
                if (pick >= 0)
                begin
                    r.run_id    = tbl_pid[pick];
                    r.first_run = (tbl_left[pick] == tbl_need[pick]);
                    tbl_left[pick]--;
                    r.finished  = (tbl_left[pick] == 0);
                end
                for (int i = 0; i < used; i++)
                    if (tbl_left[i] != 0)
                        r.all_done = 1'b0;
                dispatch_q.push_back(r);
                // saturate the tick counter
                if (now_tick != '1)
                    now_tick++;
            end
            default: ;
        endcase
    endfunction

    // Compare one accepted result against the oldest expectation
    function automatic void check_dispatch(input out_item_t got);
        out_item_t want;
        if (dispatch_q.size() == 0)
        begin
            $error("unexpected result: tick_time %0d run_id %0d", got.tick_time, got.run_id);
            failures++;
            return;
        end
        want = dispatch_q.pop_front();
        if (got.tick_time !== want.tick_time)
        begin
            $error("tick_time: expected %0d, got %0d", want.tick_time, got.tick_time);
            failures++;
        end
        if (got.run_id !== want.run_id)
        begin
            $error("run_id: expected %0d, got %0d", want.run_id, got.run_id);
            failures++;
        end
        if (got.idle !== want.idle)
        begin
            $error("idle: expected %0b, got %0b", want.idle, got.idle);
            failures++;
        end
        if (got.first_run !== want.first_run)
        begin
            $error("first_run: expected %0b, got %0b", want.first_run, got.first_run);
            failures++;
        end
        if (got.finished !== want.finished)
        begin
            $error("finished: expected %0b, got %0b", want.finished, got.finished);
            failures++;
        end
        if (got.all_done !== want.all_done)
        begin
            $error("all_done: expected %0b, got %0b", want.all_done, got.all_done);
            failures++;
        end
    endfunction

    // Build a transaction with random payload around the given action
    function automatic in_item_t scrambled(input logic [ACTION_W-1:0] act);
        in_item_t it;
        it.action  = act;
        it.slot    = 4'($urandom_range(15));
        it.proc_id = ID_W'($urandom);
        it.prio    = PRIO_W'($urandom);
        it.arrival = DUR_W'($urandom);
        it.burst   = DUR_W'($urandom);
        return it;
    endfunction

    function automatic void feed(input in_item_t it);
        pending.push_back(it);
        if (it.action != ACT_UNUSED)
            fed++;
    endfunction

    // Hold until every transaction is taken and every dispatch has come back
    task automatic wait_quiet();
        while (pending.size() != 0 || item_valid || dispatch_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic write_register(input logic idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_POLICY)
            cfg_policy = value[POLICY_W-1:0];
        else
            cfg_used = value[USED_W-1:0];
    endtask

    // Driver: present the next pending transaction, hold it while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                predict_dispatch(item);
            if (!item_valid || !item_stall)
            begin
                if (pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    item       <= pending.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Monitor: take results and stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                check_dispatch(result);
            result_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        in_item_t it;
        int       n;
        int       eff;
        int       k;
        int       horizon;
        int       gen_tick;
        bit       restart_first;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait_quiet();

        // Nothing in use after reset: ticks go idle with all work done
        feed(scrambled(ACT_TICK));
        feed(scrambled(ACT_UNUSED));
        feed(scrambled(ACT_RESTART));
        feed(scrambled(ACT_TICK));
        wait_quiet();

        // Priority policy over four slots: ties, zero burst, extreme fields, late loads
        write_register(REG_POLICY, 32'(POL_PRIO));
        write_register(REG_SLOTS, 32'd4);
        it = scrambled(ACT_LOAD);
        it.slot = 4'd0; it.proc_id = 8'hFF; it.prio = 8'h00; it.arrival = 16'd0;
        it.burst = 16'd2;
        feed(it);
        it.slot = 4'd1; it.proc_id = 8'h00; it.prio = 8'h00; it.arrival = 16'd0;
        it.burst = 16'd1;
        feed(it);
        it.slot = 4'd2; it.proc_id = 8'hA5; it.prio = 8'hFF; it.arrival = '1; it.burst = '1;
        feed(it);
        it.slot = 4'd3; it.proc_id = 8'h5A; it.prio = 8'h80; it.arrival = 16'd3;
        it.burst = 16'd0;
        feed(it);
        it.slot = 4'd15; it.proc_id = 8'hFF; it.prio = 8'hFF; it.arrival = '1; it.burst = '1;
        feed(it);
        // arrivals already passed: nothing ready until the restart
        feed(scrambled(ACT_TICK));
        feed(scrambled(ACT_RESTART));
        repeat (4) feed(scrambled(ACT_TICK));
        it.slot = 4'd1; it.proc_id = 8'h3C; it.prio = 8'h01; it.arrival = 16'd2;
        it.burst = 16'd1;
        feed(it);
        feed(scrambled(ACT_TICK));
        feed(scrambled(ACT_RESTART));
        repeat (3) feed(scrambled(ACT_TICK));
        wait_quiet();

        // Long stretch of ticks with no idling on either side
        write_register(REG_POLICY, 32'(POL_BURST));
        write_register(REG_SLOTS, 32'd3);
        steady = 1'b1;
        it = scrambled(ACT_LOAD);
        it.slot = 4'd0; it.arrival = 16'd0; it.burst = '1;
        feed(it);
        it.slot = 4'd1; it.arrival = 16'd5; it.burst = 16'd2;
        feed(it);
        it.slot = 4'd2; it.arrival = 16'd9; it.burst = 16'd1;
        feed(it);
        feed(scrambled(ACT_RESTART));
        repeat (STEADY_TICKS) feed(scrambled(ACT_TICK));
        wait_quiet();
        steady = 1'b0;

        // Random runs: load every slot in use with a restart before or after the loads, then tick with occasional noise
        fed = 0;
        while (fed < RANDOM_ITEMS)
        begin
            k = $urandom_range(99);
            if (k < 5)
                n = 0;
            else if (k < 15)
                n = SLOT_COUNT;
            else if (k < 22)
                n = $urandom_range(31, SLOT_COUNT + 1);
            else
                n = $urandom_range(8, 1);
            eff = (n > SLOT_COUNT) ? SLOT_COUNT : n;
            write_register(REG_POLICY, 32'($urandom_range(3)));
            write_register(REG_SLOTS, 32'(n));

            restart_first = 1'($urandom_range(1));
            if (restart_first)
                feed(scrambled(ACT_RESTART));
            horizon = 15;
            for (int s = 0; s < eff; s++)
            begin
                it = scrambled(ACT_LOAD);
                it.slot = 4'(s);
                if ($urandom_range(1))
                    it.prio = PRIO_W'($urandom_range(3));
                it.arrival = DUR_W'($urandom_range(12));
                k = $urandom_range(99);
                if (k < 5)
                    it.burst = '0;
                else if (k >= 8)
                    it.burst = DUR_W'($urandom_range(5, 1));
                horizon += (it.burst > 8) ? 8 : int'(it.burst);
                feed(it);
            end
            if (!restart_first)
                feed(scrambled(ACT_RESTART));

            gen_tick = 0;
            for (int t = 0; t < horizon; t++)
            begin
                k = $urandom_range(99);
                if (k < 6)
                begin
                    // new arrival mid-run, sometimes already late
                    it = scrambled(ACT_LOAD);
                    if ($urandom_range(1))
                        it.arrival = DUR_W'(gen_tick + int'($urandom_range(5)));
                    else
                        it.arrival = DUR_W'($urandom_range(gen_tick));
                    if ($urandom_range(3) != 0)
                        it.burst = DUR_W'($urandom_range(5, 1));
                    feed(it);
                end
                else if (k < 9)
                    feed(scrambled(ACT_UNUSED));
                else if (k < 10)
                begin
                    feed(scrambled(ACT_RESTART));
                    gen_tick = 0;
                end
                feed(scrambled(ACT_TICK));
                gen_tick++;
            end
            wait_quiet();
        end

        wait_quiet();
        repeat (16) @(posedge clk);
        if (failures == 0 && dispatch_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
